/* design/hcsb_pkg.sv */
// Shared types, register codes and defaults for the histogram cube spatial binner.
package hcsb_pkg;

  // Parameter defaults
  localparam int MaxWidthDef    = 128;
  localparam int MaxTimeBinsDef = 256;
  localparam int MaxHeightDef   = 1024;

  // Configuration register widths
  localparam int ImageWidthW  = 8;
  localparam int ImageHeightW = 11;
  localparam int TimeBinsW    = 9;
  localparam int BinLevelsW   = 2;
  localparam int CfgDataW     = 11;
  localparam int CfgIndexW    = 2;

  // Field widths of the sample and result beats
  localparam int SampleW      = 16;
  localparam int OutColW      = 7;
  localparam int OutRowW      = 10;
  localparam int OutBinW      = 8;
  localparam int BinnedWidthW = 8;
  localparam int BinnedHeightW = 11;

  // Largest block side mask (bin_levels up to 3)
  localparam int LvMaskW = 3;

  // Configuration register reset values
  localparam logic [ImageWidthW-1:0]  ImageWidthRst  = ImageWidthW'(128);
  localparam logic [ImageHeightW-1:0] ImageHeightRst = ImageHeightW'(128);
  localparam logic [TimeBinsW-1:0]    TimeBinsRst    = TimeBinsW'(256);
  localparam logic [BinLevelsW-1:0]   BinLevelsRst   = BinLevelsW'(1);

  // Configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_TIME_BINS    = 2'd2,
    CFG_BIN_LEVELS   = 2'd3
  } cfg_reg_e;

endpackage

/* design/hcsb_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module hcsb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port: old data on a same-address write, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/histogram_cube_spatial_binner.sv */
// Top level of the histogram cube spatial binner: counters, line store RMW, result register.
//
// Usage:
//   Sample beats enter on in_valid_i / in_stall_o, one 16-bit count per beat, in
//   raster order: time bin fastest, then column, then row. Square blocks of
//   2^bin_levels pixels on a side are summed per time bin (modulo 65536); pixels
//   in leftover right columns and bottom rows are dropped. A result beat leaves on
//   out_valid_o / out_stall_i at the last sample of each block for each time bin.
//   Throughput: one sample per cycle while the input is not stalled. Each sample does one
//   read-modify-write of the line store RAM (one read port, one write port);
//   a same-address access from the previous sample is forwarded.
//   Result path: taking the last sample beat of a block loads the RAM read and the
//   update stage; the update stage then loads the output register, unless it is
//   blocked by a waiting result on a stalled output.
//   Stall: the output register holds a waiting result while the next samples
//   keep flowing; input stalls only when a second result is ready behind it.
//   Reset: counters clear, configuration returns to 128 x 128 pixels, 256 bins,
//   one halving. The line store is not cleared: the first block row of a frame
//   writes every entry before it is read. Configuration writes go through
//   cfg_we_i / cfg_index_i / cfg_data_i only while idle: the user's duty, not enforced.
module histogram_cube_spatial_binner
  import hcsb_pkg::*;
#(
  parameter int MAX_WIDTH     = MaxWidthDef,
  parameter int MAX_TIME_BINS = MaxTimeBinsDef,
  parameter int MAX_HEIGHT    = MaxHeightDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [CfgIndexW-1:0]     cfg_index_i,
  input  logic [CfgDataW-1:0]      cfg_data_i,
  // sample channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [SampleW-1:0]       sample_count_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [SampleW-1:0]       binned_count_o,
  output logic [OutColW-1:0]       out_col_o,
  output logic [OutRowW-1:0]       out_row_o,
  output logic [OutBinW-1:0]       out_bin_o,
  output logic                     last_of_frame_o,
  output logic [BinnedWidthW-1:0]  binned_width_o,
  output logic [BinnedHeightW-1:0] binned_height_o
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int BIN_W  = (MAX_TIME_BINS > 1) ? $clog2(MAX_TIME_BINS) : 1;
  localparam int WD_W   = $clog2(MAX_WIDTH + 1);
  localparam int HD_W   = $clog2(MAX_HEIGHT + 1);
  localparam int TD_W   = $clog2(MAX_TIME_BINS + 1);
  localparam int DEPTH  = MAX_WIDTH * MAX_TIME_BINS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PROD_W = COL_W + TD_W;

  // Configuration registers
  logic [ImageWidthW-1:0]  image_width_q;
  logic [ImageHeightW-1:0] image_height_q;
  logic [TimeBinsW-1:0]    time_bins_q;
  logic [BinLevelsW-1:0]   bin_levels_q;

  // Position counters
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [BIN_W-1:0] bin_q, bin_d;

  // Clamped and derived dimensions
  logic [WD_W-1:0]    w_cl, w_trim, bw;
  logic [HD_W-1:0]    h_cl, h_trim, bh;
  logic [TD_W-1:0]    t_cl;
  logic [LvMaskW-1:0] lv_mask;

  // Accept-side decode
  logic              accept;
  logic              a_touch, a_first, a_emit, a_last;
  logic [COL_W-1:0]  a_oc;
  logic [ROW_W-1:0]  a_orow;
  logic [PROD_W-1:0] a_prod, a_sum;
  logic [ADDR_W-1:0] a_addr;
  logic              a_hit;
  logic [TD_W-1:0]   bin_inc;
  logic [WD_W-1:0]   col_inc;
  logic [HD_W-1:0]   row_inc;

  // Update stage
  logic               b_valid_q, b_touch_q, b_emit_q, b_first_q, b_hit_q, b_last_q;
  logic [ADDR_W-1:0]  b_addr_q;
  logic [SampleW-1:0] b_sample_q;
  logic [COL_W-1:0]   b_oc_q;
  logic [ROW_W-1:0]   b_orow_q;
  logic [BIN_W-1:0]   b_bin_q;
  logic [WD_W-1:0]    b_bw_q;
  logic [HD_W-1:0]    b_bh_q;
  logic               b_block;
  logic               b_go;
  logic               b_wr;
  logic [SampleW-1:0] rd_data, b_base, b_acc;
  logic [SampleW-1:0] fwd_q;

  // Output register
  logic               out_valid_q;
  logic               out_load;
  logic [SampleW-1:0] out_count_q;
  logic [COL_W-1:0]   out_oc_q;
  logic [ROW_W-1:0]   out_orow_q;
  logic [BIN_W-1:0]   out_bin_q;
  logic               out_last_q;
  logic [WD_W-1:0]    out_bw_q;
  logic [HD_W-1:0]    out_bh_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= ImageWidthRst;
      image_height_q <= ImageHeightRst;
      time_bins_q    <= TimeBinsRst;
      bin_levels_q   <= BinLevelsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[ImageWidthW-1:0];
        CFG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[ImageHeightW-1:0];
        CFG_TIME_BINS:    time_bins_q    <= cfg_data_i[TimeBinsW-1:0];
        CFG_BIN_LEVELS:   bin_levels_q   <= cfg_data_i[BinLevelsW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp dimensions: zero acts as one, oversize acts as the maximum
  always_comb begin
    if (image_width_q == '0) begin
      w_cl = WD_W'(1);
    end else if (32'(image_width_q) > MAX_WIDTH) begin
      w_cl = WD_W'(MAX_WIDTH);
    end else begin
      w_cl = WD_W'(image_width_q);
    end
    if (image_height_q == '0) begin
      h_cl = HD_W'(1);
    end else if (32'(image_height_q) > MAX_HEIGHT) begin
      h_cl = HD_W'(MAX_HEIGHT);
    end else begin
      h_cl = HD_W'(image_height_q);
    end
    if (time_bins_q == '0) begin
      t_cl = TD_W'(1);
    end else if (32'(time_bins_q) > MAX_TIME_BINS) begin
      t_cl = TD_W'(MAX_TIME_BINS);
    end else begin
      t_cl = TD_W'(time_bins_q);
    end
  end

  // Block geometry
  assign lv_mask = LvMaskW'((LvMaskW'(1) << bin_levels_q) - LvMaskW'(1));
  assign w_trim  = w_cl & ~WD_W'(lv_mask);
  assign h_trim  = h_cl & ~HD_W'(lv_mask);
  assign bw      = w_cl >> bin_levels_q;
  assign bh      = h_cl >> bin_levels_q;

  // Decode of the current sample position
  assign a_oc   = col_q >> bin_levels_q;
  assign a_orow = row_q >> bin_levels_q;
  assign a_touch = (WD_W'(col_q) < w_trim) && (HD_W'(row_q) < h_trim)
                   && (TD_W'(bin_q) < t_cl);
  assign a_first = ((col_q & COL_W'(lv_mask)) == '0) && ((row_q & ROW_W'(lv_mask)) == '0);
  assign a_emit  = ((col_q & COL_W'(lv_mask)) == COL_W'(lv_mask))
                   && ((row_q & ROW_W'(lv_mask)) == ROW_W'(lv_mask));
  assign a_last  = (WD_W'(a_oc) == bw - WD_W'(1)) && (HD_W'(a_orow) == bh - HD_W'(1))
                   && (TD_W'(bin_q) == t_cl - TD_W'(1));

  // Line store address: output column times bin count plus bin
  assign a_prod = PROD_W'(a_oc) * PROD_W'(t_cl);
  assign a_sum  = a_prod + PROD_W'(bin_q);
  assign a_addr = ADDR_W'(a_sum);

  // Handshake: stall only when a second result would overrun a stalled output
  assign b_block    = b_valid_q && b_touch_q && b_emit_q && out_valid_q && out_stall_i;
  assign b_go       = !b_block;
  assign in_stall_o = b_block;
  assign accept     = in_valid_i && !in_stall_o;

  // Forward the write of the previous sample when it hits the address read now
  assign b_wr  = b_valid_q && b_touch_q && b_go;
  assign a_hit = b_wr && (b_addr_q == a_addr);

  // Counter advance: bin fastest, then column, then row
  always_comb begin
    bin_inc = TD_W'(bin_q) + TD_W'(1);
    col_inc = WD_W'(col_q) + WD_W'(1);
    row_inc = HD_W'(row_q) + HD_W'(1);
    bin_d   = bin_q;
    col_d   = col_q;
    row_d   = row_q;
    if (bin_inc >= t_cl) begin
      bin_d = '0;
      if (col_inc >= w_cl) begin
        col_d = '0;
        if (row_inc >= h_cl) begin
          row_d = '0;
        end else begin
          row_d = ROW_W'(row_inc);
        end
      end else begin
        col_d = COL_W'(col_inc);
      end
    end else begin
      bin_d = BIN_W'(bin_inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      bin_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
      bin_q <= bin_d;
    end
  end

  // Line store
  hcsb_ram #(
    .WIDTH (SampleW),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (b_wr),
    .waddr_i (b_addr_q),
    .wdata_i (b_acc),
    .re_i    (accept && a_touch),
    .raddr_i (a_addr),
    .rdata_o (rd_data)
  );

  // Update stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      b_touch_q <= 1'b0;
      b_emit_q  <= 1'b0;
    end else if (accept) begin
      b_valid_q <= 1'b1;
      b_touch_q <= a_touch;
      b_emit_q  <= a_emit;
    end else if (b_go) begin
      b_valid_q <= 1'b0;
    end
  end

  // Update stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_first_q  <= a_first;
      b_hit_q    <= a_hit;
      b_last_q   <= a_last;
      b_addr_q   <= a_addr;
      b_sample_q <= sample_count_i;
      b_oc_q     <= a_oc;
      b_orow_q   <= a_orow;
      b_bin_q    <= bin_q;
      b_bw_q     <= bw;
      b_bh_q     <= bh;
      fwd_q      <= b_acc;
    end
  end

  // Accumulate: the first pixel of a block starts the sum
  assign b_base = b_hit_q ? fwd_q : rd_data;
  assign b_acc  = b_first_q ? b_sample_q : b_base + b_sample_q;

  // Output register
  assign out_load = b_valid_q && b_touch_q && b_emit_q && b_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_count_q <= b_acc;
      out_oc_q    <= b_oc_q;
      out_orow_q  <= b_orow_q;
      out_bin_q   <= b_bin_q;
      out_last_q  <= b_last_q;
      out_bw_q    <= b_bw_q;
      out_bh_q    <= b_bh_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign binned_count_o  = out_count_q;
  assign out_col_o       = OutColW'(out_oc_q);
  assign out_row_o       = OutRowW'(out_orow_q);
  assign out_bin_o       = OutBinW'(out_bin_q);
  assign last_of_frame_o = out_last_q;
  assign binned_width_o  = BinnedWidthW'(out_bw_q);
  assign binned_height_o = BinnedHeightW'(out_bh_q);

endmodule
